@@ sv/assert_macros.svh @@
// assertion macros for the port checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion, inactive while reset is high
`define CHK_ASSERT(name, clk, rst, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("port checker assertion failed");

// concurrent assertion that also holds across reset
`define CHK_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("port checker assertion failed");

`endif

@@ sv/i2cmts_pkg.sv @@
// types, codes and constants of the i2c master transfer sequencer
package i2cmts_pkg;

  localparam int WRITE_BUFFER_DEPTH_DEFAULT = 64;

  // item operation codes
  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_LOAD  = 2'd1,
    OP_EVENT = 2'd2
  } op_t;

  // acknowledge control codes
  typedef enum logic [1:0] {
    ACK_KEEP = 2'd0,
    ACK_ACK  = 2'd1,
    ACK_NACK = 2'd2
  } ack_t;

  // bus engine status codes
  localparam logic [7:0] ST_START       = 8'h08;
  localparam logic [7:0] ST_RSTART      = 8'h10;
  localparam logic [7:0] ST_SLA_W_ACK   = 8'h18;
  localparam logic [7:0] ST_DATA_W_ACK  = 8'h28;
  localparam logic [7:0] ST_ARB_LOST    = 8'h38;
  localparam logic [7:0] ST_SLA_R_ACK   = 8'h40;
  localparam logic [7:0] ST_DATA_R_ACK  = 8'h50;
  localparam logic [7:0] ST_DATA_R_NACK = 8'h58;

  // input item
  typedef struct packed {
    logic [1:0] op;
    logic [6:0] device_address;
    logic       read_flag;
    logic [7:0] register_address;
    logic [7:0] byte_count;
    logic [7:0] write_byte;
    logic [7:0] status_code;
    logic [7:0] received_byte;
  } in_item_t;

  // result item
  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       set_start;
    logic       clear_start;
    logic [1:0] ack_control;
    logic       set_stop;
    logic       release_si;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic       done_res;
    logic       failed;
    logic [7:0] fail_status;
  } out_item_t;

  // transfer control state
  typedef struct packed {
    logic       busy;
    logic [7:0] target_address_rw;
    logic [7:0] first_register;
    logic [7:0] bytes_left;
  } ctrl_t;

  // write queue commands from the step logic
  typedef struct packed {
    logic load;
    logic pop;
    logic clear;
    logic rewind;
  } buf_cmd_t;

  // write queue status seen by the step logic
  typedef struct packed {
    logic       full;
    logic       count_over;
    logic       read_ok;
    logic [7:0] read_data;
  } buf_stat_t;

endpackage

@@ sv/i2cmts_if.sv @@
// valid/ready channels carrying input and result items
interface i2cmts_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [6:0] device_address;
  logic       read_flag;
  logic [7:0] register_address;
  logic [7:0] byte_count;
  logic [7:0] write_byte;
  logic [7:0] status_code;
  logic [7:0] received_byte;

  modport source (
    output valid, op, device_address, read_flag, register_address, byte_count,
           write_byte, status_code, received_byte,
    input  ready
  );
  modport sink (
    input  valid, op, device_address, read_flag, register_address, byte_count,
           write_byte, status_code, received_byte,
    output ready
  );
endinterface

interface i2cmts_out_if;
  logic       valid;
  logic       ready;
  logic       tx_valid;
  logic [7:0] tx_byte;
  logic       set_start;
  logic       clear_start;
  logic [1:0] ack_control;
  logic       set_stop;
  logic       release_si;
  logic       rx_valid;
  logic [7:0] rx_byte;
  logic       done_res;
  logic       failed;
  logic [7:0] fail_status;

  modport source (
    output valid, tx_valid, tx_byte, set_start, clear_start, ack_control, set_stop,
           release_si, rx_valid, rx_byte, done_res, failed, fail_status,
    input  ready
  );
  modport sink (
    input  valid, tx_valid, tx_byte, set_start, clear_start, ack_control, set_stop,
           release_si, rx_valid, rx_byte, done_res, failed, fail_status,
    output ready
  );
endinterface

@@ sv/i2c_master_transfer_sequencer.sv @@
// accepted items are processed in the input register, results offered from the result register
// one item per cycle unless the output stalls; no-result items (loads, idle events) add no bubble
// the write queue is a one-port-write memory with a registered read kept at the current read index
// reset: synchronous, clears control state, queue indices and both stage valids
// queue contents are not cleared; entries are only read after they are written
// top level of the i2c master transfer sequencer
module i2c_master_transfer_sequencer #(
  parameter int WRITE_BUFFER_DEPTH = i2cmts_pkg::WRITE_BUFFER_DEPTH_DEFAULT
) (
  input logic         clk,
  input logic         rst,
  i2cmts_in_if.sink   in_ch,
  i2cmts_out_if.source out_ch
);

  localparam int FW = $clog2(WRITE_BUFFER_DEPTH + 1);
  localparam int AW = (WRITE_BUFFER_DEPTH > 1) ? $clog2(WRITE_BUFFER_DEPTH) : 1;
  localparam logic [FW-1:0] DEPTH_W = FW'(WRITE_BUFFER_DEPTH);

  logic                  s1_valid;
  i2cmts_pkg::in_item_t  s1_item;
  i2cmts_pkg::in_item_t  in_item;
  logic                  out_valid;
  i2cmts_pkg::out_item_t out_item;
  i2cmts_pkg::ctrl_t     ctrl;
  i2cmts_pkg::ctrl_t     ctrl_next;
  i2cmts_pkg::buf_cmd_t  cmd;
  i2cmts_pkg::buf_stat_t stat;
  i2cmts_pkg::out_item_t res;
  logic                  has_res;
  logic                  out_free;
  logic                  s1_go;
  logic                  take;
  logic [FW-1:0]         fill;
  logic [FW-1:0]         fill_next;
  logic [FW-1:0]         rd_idx;
  logic [FW-1:0]         rd_idx_next;
  logic                  wr_en;
  logic [7:0]            rd_data;
  logic [7:0]            mem [WRITE_BUFFER_DEPTH];

  // gather the input item
  assign in_item = '{op: in_ch.op, device_address: in_ch.device_address,
                     read_flag: in_ch.read_flag, register_address: in_ch.register_address,
                     byte_count: in_ch.byte_count, write_byte: in_ch.write_byte,
                     status_code: in_ch.status_code, received_byte: in_ch.received_byte};

  // stage handshake
  assign out_free    = !out_valid || out_ch.ready;
  assign s1_go       = s1_valid && (!has_res || out_free);
  assign in_ch.ready = !s1_valid || s1_go;
  assign take        = in_ch.valid && in_ch.ready;

  // queue status for the step logic
  assign stat.full       = (fill >= DEPTH_W);
  assign stat.count_over = (9'(s1_item.byte_count) > 9'(fill));
  assign stat.read_ok    = (rd_idx < fill);
  assign stat.read_data  = rd_data;

  i2cmts_step u_step (
    .item      (s1_item),
    .ctrl      (ctrl),
    .stat      (stat),
    .ctrl_next (ctrl_next),
    .cmd       (cmd),
    .has_res   (has_res),
    .res       (res)
  );

  // queue index updates
  assign wr_en = s1_go && cmd.load;
  always_comb begin
    fill_next   = fill;
    rd_idx_next = rd_idx;
    if (s1_go) begin
      if (cmd.clear) begin
        fill_next = '0;
      end else if (cmd.load) begin
        fill_next = fill + FW'(1);
      end
      if (cmd.clear || cmd.rewind) begin
        rd_idx_next = '0;
      end else if (cmd.pop) begin
        rd_idx_next = rd_idx + FW'(1);
      end
    end
  end

  // write queue memory, read data follows the next read index with write bypass
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[fill[AW-1:0]] <= s1_item.write_byte;
    end
    if (wr_en && (fill == rd_idx_next)) begin
      rd_data <= s1_item.write_byte;
    end else begin
      rd_data <= mem[rd_idx_next[AW-1:0]];
    end
  end

  // control state and queue indices
  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl   <= '0;
      fill   <= '0;
      rd_idx <= '0;
    end else begin
      if (s1_go) begin
        ctrl <= ctrl_next;
      end
      fill   <= fill_next;
      rd_idx <= rd_idx_next;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_item <= in_item;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_go && has_res;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_go && has_res) begin
      out_item <= res;
    end
  end

  // drive the result channel
  assign out_ch.valid       = out_valid;
  assign out_ch.tx_valid    = out_item.tx_valid;
  assign out_ch.tx_byte     = out_item.tx_byte;
  assign out_ch.set_start   = out_item.set_start;
  assign out_ch.clear_start = out_item.clear_start;
  assign out_ch.ack_control = out_item.ack_control;
  assign out_ch.set_stop    = out_item.set_stop;
  assign out_ch.release_si  = out_item.release_si;
  assign out_ch.rx_valid    = out_item.rx_valid;
  assign out_ch.rx_byte     = out_item.rx_byte;
  assign out_ch.done_res    = out_item.done_res;
  assign out_ch.failed      = out_item.failed;
  assign out_ch.fail_status = out_item.fail_status;

endmodule

@@ sv/i2cmts_step.sv @@
// combinational step: one item against the control state gives result and updates
module i2cmts_step (
  input  i2cmts_pkg::in_item_t  item,
  input  i2cmts_pkg::ctrl_t     ctrl,
  input  i2cmts_pkg::buf_stat_t stat,
  output i2cmts_pkg::ctrl_t     ctrl_next,
  output i2cmts_pkg::buf_cmd_t  cmd,
  output logic                  has_res,
  output i2cmts_pkg::out_item_t res
);

  logic       is_read;
  logic [7:0] left_dec;

  assign is_read  = ctrl.target_address_rw[0];
  assign left_dec = (ctrl.bytes_left != 8'd0) ? ctrl.bytes_left - 8'd1 : 8'd0;

  always_comb begin
    ctrl_next = ctrl;
    cmd       = '0;
    has_res   = 1'b0;
    res       = '0;
    case (i2cmts_pkg::op_t'(item.op))
      // new transfer, rejected while busy or when a write finds the queue short
      i2cmts_pkg::OP_START: begin
        has_res = 1'b1;
        if (ctrl.busy || (!item.read_flag && stat.count_over)) begin
          res.failed = 1'b1;
        end else begin
          ctrl_next.busy              = 1'b1;
          ctrl_next.target_address_rw = {item.device_address, item.read_flag};
          ctrl_next.first_register    = item.register_address;
          ctrl_next.bytes_left        = item.byte_count;
          cmd.rewind                  = 1'b1;
          res.set_start               = 1'b1;
        end
      end
      // queue a write byte while idle and the queue is not full
      i2cmts_pkg::OP_LOAD: begin
        cmd.load = !ctrl.busy && !stat.full;
      end
      // bus status event
      i2cmts_pkg::OP_EVENT: begin
        if (ctrl.busy) begin
          has_res = 1'b1;
          case (item.status_code)
            i2cmts_pkg::ST_START: begin
              res.tx_valid   = 1'b1;
              res.tx_byte    = {ctrl.target_address_rw[7:1], 1'b0};
              res.release_si = 1'b1;
            end
            i2cmts_pkg::ST_RSTART: begin
              res.tx_valid   = 1'b1;
              res.tx_byte    = {ctrl.target_address_rw[7:1], 1'b1};
              res.release_si = 1'b1;
            end
            i2cmts_pkg::ST_SLA_W_ACK: begin
              res.clear_start = 1'b1;
              if (ctrl.bytes_left == 8'd0) begin
                res.set_stop   = 1'b1;
                res.release_si = 1'b1;
                res.done_res   = 1'b1;
                ctrl_next.busy = 1'b0;
                cmd.clear      = 1'b1;
              end else begin
                res.tx_valid   = 1'b1;
                res.tx_byte    = ctrl.first_register;
                res.release_si = 1'b1;
              end
            end
            i2cmts_pkg::ST_DATA_W_ACK: begin
              if (is_read) begin
                res.set_start  = 1'b1;
                res.release_si = 1'b1;
              end else if (ctrl.bytes_left == 8'd0) begin
                res.set_stop    = 1'b1;
                res.clear_start = 1'b1;
                res.release_si  = 1'b1;
                res.done_res    = 1'b1;
                ctrl_next.busy  = 1'b0;
                cmd.clear       = 1'b1;
              end else begin
                res.tx_valid         = 1'b1;
                res.tx_byte          = stat.read_ok ? stat.read_data : 8'd0;
                res.release_si       = 1'b1;
                ctrl_next.bytes_left = ctrl.bytes_left - 8'd1;
                cmd.pop              = 1'b1;
              end
            end
            i2cmts_pkg::ST_SLA_R_ACK: begin
              res.clear_start = 1'b1;
              res.ack_control = (ctrl.bytes_left > 8'd1) ? i2cmts_pkg::ACK_ACK
                                                         : i2cmts_pkg::ACK_NACK;
              res.release_si  = 1'b1;
            end
            i2cmts_pkg::ST_DATA_R_ACK: begin
              res.rx_valid         = 1'b1;
              res.rx_byte          = item.received_byte;
              ctrl_next.bytes_left = left_dec;
              res.ack_control      = (left_dec == 8'd1) ? i2cmts_pkg::ACK_NACK
                                                        : i2cmts_pkg::ACK_ACK;
              res.release_si       = 1'b1;
            end
            i2cmts_pkg::ST_DATA_R_NACK: begin
              res.rx_valid         = 1'b1;
              res.rx_byte          = item.received_byte;
              ctrl_next.bytes_left = 8'd0;
              res.set_stop         = 1'b1;
              res.clear_start      = 1'b1;
              res.release_si       = 1'b1;
              res.done_res         = 1'b1;
              ctrl_next.busy       = 1'b0;
              cmd.clear            = 1'b1;
            end
            // arbitration lost: end without stop or release
            i2cmts_pkg::ST_ARB_LOST: begin
              res.done_res    = 1'b1;
              res.failed      = 1'b1;
              res.fail_status = item.status_code;
              ctrl_next.busy  = 1'b0;
              cmd.clear       = 1'b1;
            end
            // bus error, nack or unknown status: fail with stop
            default: begin
              res.set_stop    = 1'b1;
              res.clear_start = 1'b1;
              res.release_si  = 1'b1;
              res.done_res    = 1'b1;
              res.failed      = 1'b1;
              res.fail_status = item.status_code;
              ctrl_next.busy  = 1'b0;
              cmd.clear       = 1'b1;
            end
          endcase
        end
      end
      default: begin
        has_res = 1'b0;
      end
    endcase
  end

endmodule

@@ sv/i2cmts_checker.sv @@
// port checker for the i2c master transfer sequencer, bound to the top level
`include "assert_macros.svh"

module i2cmts_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic       tx_valid,
  input logic [7:0] tx_byte,
  input logic       clear_start,
  input logic       set_stop,
  input logic       release_si,
  input logic       done_res,
  input logic       failed,
  input logic [7:0] fail_status
);

  // a stalled result item holds
  `CHK_ASSERT(a_out_hold, clk, rst, (out_valid && !out_ready) |=>
    (out_valid && $stable(tx_byte) && $stable(fail_status) && $stable(done_res)))

  // reset empties the result stage
  `CHK_ASSERT_ALWAYS(a_rst_empty, clk, rst |=> !out_valid)

  // a stop request always comes with start clear, release and end of transfer
  `CHK_ASSERT(a_stop_bundle, clk, rst, (out_valid && set_stop) |->
    (clear_start && release_si && done_res && !tx_valid))

  // a successful end always requests a stop and reports no status
  `CHK_ASSERT(a_ok_end, clk, rst, (out_valid && done_res && !failed) |->
    (set_stop && fail_status == 8'd0))

endmodule

bind i2c_master_transfer_sequencer i2cmts_checker u_i2cmts_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .tx_valid    (out_ch.tx_valid),
  .tx_byte     (out_ch.tx_byte),
  .clear_start (out_ch.clear_start),
  .set_stop    (out_ch.set_stop),
  .release_si  (out_ch.release_si),
  .done_res    (out_ch.done_res),
  .failed      (out_ch.failed),
  .fail_status (out_ch.fail_status)
);

@@ sim/testbench.sv @@
`timescale 1ns / 100ps
// testbench of the i2c master transfer sequencer: directed and random transfers against a predictor
module testbench;

  localparam int QUEUE_DEPTH = i2cmts_pkg::WRITE_BUFFER_DEPTH_DEFAULT;
  localparam int TARGET_ITEMS = 1750;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 8;
  localparam logic [1:0] OP_UNDEFINED = 2'd3;
  localparam logic [7:0] ST_BUS_ERROR = 8'h00;

  typedef enum {RX_STEADY, RX_LIGHT, RX_HEAVY} rx_mode_t;

  // predicts the bus actions of each item and checks them against the block
  class transfer_scoreboard;
    bit busy;
    logic [7:0] addr_rw;
    logic [7:0] first_reg;
    logic [7:0] bytes_left;
    logic [7:0] queue_mem [QUEUE_DEPTH];
    int unsigned fill_idx;
    int unsigned read_idx;
    i2cmts_pkg::out_item_t actions;
    i2cmts_pkg::out_item_t expected_q[$];
    int unsigned errors;

    function new();
      busy = 1'b0;
      addr_rw = '0;
      first_reg = '0;
      bytes_left = '0;
      fill_idx = 0;
      read_idx = 0;
      errors = 0;
    endfunction

    task report_mismatch(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    function void request_stop();
      actions.set_stop = 1'b1;
      actions.clear_start = 1'b1;
      actions.release_si = 1'b1;
    endfunction

    // transfer over: go idle and empty the write queue
    function void end_transfer(bit fail, logic [7:0] st);
      busy = 1'b0;
      fill_idx = 0;
      read_idx = 0;
      actions.done_res = 1'b1;
      actions.failed = fail;
      actions.fail_status = fail ? st : 8'h00;
    endfunction

    // answer to one status event of the bus engine
    function void bus_event(logic [7:0] st, logic [7:0] rx);
      case (st)
        i2cmts_pkg::ST_START: begin
          actions.tx_valid = 1'b1;
          actions.tx_byte = {addr_rw[7:1], 1'b0};
          actions.release_si = 1'b1;
        end
        i2cmts_pkg::ST_RSTART: begin
          actions.tx_valid = 1'b1;
          actions.tx_byte = {addr_rw[7:1], 1'b1};
          actions.release_si = 1'b1;
        end
        i2cmts_pkg::ST_SLA_W_ACK: begin
          actions.clear_start = 1'b1;
          if (bytes_left == 0) begin
            request_stop();
            end_transfer(1'b0, st);
          end else begin
            actions.tx_valid = 1'b1;
            actions.tx_byte = first_reg;
            actions.release_si = 1'b1;
          end
        end
        i2cmts_pkg::ST_DATA_W_ACK: begin
          if (addr_rw[0]) begin
            actions.set_start = 1'b1;
            actions.release_si = 1'b1;
          end else if (bytes_left == 0) begin
            request_stop();
            end_transfer(1'b0, st);
          end else begin
            actions.tx_byte = (read_idx < fill_idx && read_idx < QUEUE_DEPTH) ?
                              queue_mem[read_idx] : 8'h00;
            read_idx++;
            bytes_left--;
            actions.tx_valid = 1'b1;
            actions.release_si = 1'b1;
          end
        end
        i2cmts_pkg::ST_SLA_R_ACK: begin
          actions.clear_start = 1'b1;
          actions.ack_control = (bytes_left > 1) ? i2cmts_pkg::ACK_ACK : i2cmts_pkg::ACK_NACK;
          actions.release_si = 1'b1;
        end
        i2cmts_pkg::ST_DATA_R_ACK: begin
          actions.rx_valid = 1'b1;
          actions.rx_byte = rx;
          if (bytes_left > 0) bytes_left--;
          actions.ack_control = (bytes_left == 1) ? i2cmts_pkg::ACK_NACK : i2cmts_pkg::ACK_ACK;
          actions.release_si = 1'b1;
        end
        i2cmts_pkg::ST_DATA_R_NACK: begin
          actions.rx_valid = 1'b1;
          actions.rx_byte = rx;
          bytes_left = '0;
          request_stop();
          end_transfer(1'b0, st);
        end
        // arbitration loss gives up the bus without a stop
        i2cmts_pkg::ST_ARB_LOST: end_transfer(1'b1, st);
        default: begin
          request_stop();
          end_transfer(1'b1, st);
        end
      endcase
    endfunction

    function void note_input(i2cmts_pkg::in_item_t it);
      bit has_result;
      has_result = 1'b0;
      actions = '0;
      case (it.op)
        i2cmts_pkg::OP_START: begin
          has_result = 1'b1;
          if (busy || (!it.read_flag && it.byte_count > fill_idx)) begin
            actions.failed = 1'b1;
          end else begin
            busy = 1'b1;
            addr_rw = {it.device_address, it.read_flag};
            first_reg = it.register_address;
            bytes_left = it.byte_count;
            read_idx = 0;
            actions.set_start = 1'b1;
          end
        end
        i2cmts_pkg::OP_LOAD: begin
          if (!busy && fill_idx < QUEUE_DEPTH) begin
            queue_mem[fill_idx] = it.write_byte;
            fill_idx++;
          end
        end
        i2cmts_pkg::OP_EVENT: begin
          if (busy) begin
            has_result = 1'b1;
            bus_event(it.status_code, it.received_byte);
          end
        end
        default: ;
      endcase
      if (has_result) expected_q.push_back(actions);
    endfunction

    task compare_field(string name, logic [7:0] got, logic [7:0] want);
      if (got !== want) report_mismatch($sformatf("%s got %h expected %h", name, got, want));
    endtask

    task check_result(i2cmts_pkg::out_item_t got);
      i2cmts_pkg::out_item_t want;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result %h", got));
        return;
      end
      want = expected_q.pop_front();
      compare_field("tx_valid", 8'(got.tx_valid), 8'(want.tx_valid));
      compare_field("tx_byte", got.tx_byte, want.tx_byte);
      compare_field("set_start", 8'(got.set_start), 8'(want.set_start));
      compare_field("clear_start", 8'(got.clear_start), 8'(want.clear_start));
      compare_field("ack_control", 8'(got.ack_control), 8'(want.ack_control));
      compare_field("set_stop", 8'(got.set_stop), 8'(want.set_stop));
      compare_field("release_si", 8'(got.release_si), 8'(want.release_si));
      compare_field("rx_valid", 8'(got.rx_valid), 8'(want.rx_valid));
      compare_field("rx_byte", got.rx_byte, want.rx_byte);
      compare_field("done_res", 8'(got.done_res), 8'(want.done_res));
      compare_field("failed", 8'(got.failed), 8'(want.failed));
      compare_field("fail_status", got.fail_status, want.fail_status);
    endtask
  endclass

  logic clk;
  logic rst;
  i2cmts_in_if in_ch ();
  i2cmts_out_if out_ch ();
  transfer_scoreboard sb = new();
  int unsigned cycle_count = 0;
  int unsigned burst_left = 0;
  int unsigned items_sent = 0;
  int unsigned stall_left = 0;
  rx_mode_t stall_mode = RX_STEADY;

  i2c_master_transfer_sequencer i_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // accepted input items feed the predictor
  always @(posedge clk) begin
    i2cmts_pkg::in_item_t seen;
    if (!rst && in_ch.valid && in_ch.ready) begin
      seen.op = in_ch.op;
      seen.device_address = in_ch.device_address;
      seen.read_flag = in_ch.read_flag;
      seen.register_address = in_ch.register_address;
      seen.byte_count = in_ch.byte_count;
      seen.write_byte = in_ch.write_byte;
      seen.status_code = in_ch.status_code;
      seen.received_byte = in_ch.received_byte;
      sb.note_input(seen);
    end
  end

  // accepted results are checked
  always @(posedge clk) begin
    i2cmts_pkg::out_item_t got;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got.tx_valid = out_ch.tx_valid;
      got.tx_byte = out_ch.tx_byte;
      got.set_start = out_ch.set_start;
      got.clear_start = out_ch.clear_start;
      got.ack_control = out_ch.ack_control;
      got.set_stop = out_ch.set_stop;
      got.release_si = out_ch.release_si;
      got.rx_valid = out_ch.rx_valid;
      got.rx_byte = out_ch.rx_byte;
      got.done_res = out_ch.done_res;
      got.failed = out_ch.failed;
      got.fail_status = out_ch.fail_status;
      sb.check_result(got);
    end
  end

  // receiver runs in stretches of no, light and heavy back-pressure
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = rx_mode_t'($urandom_range(0, 2));
      stall_left = $urandom_range(20, 300);
    end
    stall_left--;
    case (stall_mode)
      RX_STEADY: out_ch.ready <= 1'b1;
      RX_LIGHT:  out_ch.ready <= ($urandom_range(0, 3) != 0);
      default:   out_ch.ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  function automatic i2cmts_pkg::in_item_t random_item();
    logic [63:0] bits;
    bits = {$urandom, $urandom};
    return bits[$bits(i2cmts_pkg::in_item_t)-1:0];
  endfunction

  // drive one item and wait until it is taken; bursts with random gaps
  task automatic send_item(i2cmts_pkg::in_item_t it);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end
    end
    in_ch.valid <= 1'b1;
    in_ch.op <= it.op;
    in_ch.device_address <= it.device_address;
    in_ch.read_flag <= it.read_flag;
    in_ch.register_address <= it.register_address;
    in_ch.byte_count <= it.byte_count;
    in_ch.write_byte <= it.write_byte;
    in_ch.status_code <= it.status_code;
    in_ch.received_byte <= it.received_byte;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    burst_left--;
    items_sent++;
  endtask

  task automatic send_start(logic rd, logic [6:0] dev, logic [7:0] reg_addr, logic [7:0] cnt);
    i2cmts_pkg::in_item_t it;
    it = random_item();
    it.op = i2cmts_pkg::OP_START;
    it.read_flag = rd;
    it.device_address = dev;
    it.register_address = reg_addr;
    it.byte_count = cnt;
    send_item(it);
  endtask

  task automatic send_load(logic [7:0] data);
    i2cmts_pkg::in_item_t it;
    it = random_item();
    it.op = i2cmts_pkg::OP_LOAD;
    it.write_byte = data;
    send_item(it);
  endtask

  task automatic send_event(logic [7:0] st, logic [7:0] rx);
    i2cmts_pkg::in_item_t it;
    it = random_item();
    it.op = i2cmts_pkg::OP_EVENT;
    it.status_code = st;
    it.received_byte = rx;
    send_item(it);
  endtask

  // one well-formed transfer with random content, sometimes cut short by an error
  task automatic run_transfer();
    logic [7:0] codes[$];
    logic [7:0] bad;
    int unsigned count;
    int unsigned nloads;
    int unsigned cut;
    bit is_read;
    bit accepted;
    is_read = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 19) == 0) begin
      count = is_read ? $urandom_range(0, 255) : $urandom_range(0, 64);
    end else begin
      count = $urandom_range(0, 5);
    end
    nloads = 0;
    if (!is_read) begin
      nloads = count + $urandom_range(0, 2);
      if ($urandom_range(0, 29) == 0) nloads = QUEUE_DEPTH + 6;
      if ($urandom_range(0, 11) == 0) count = ($urandom_range(0, 1) != 0) ? 255 : nloads + 1;
    end
    accepted = is_read || count <= nloads;
    repeat (nloads) send_load(8'($urandom_range(0, 255)));
    send_start(is_read, 7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)), 8'(count));

    // status sequence the bus engine reports for this transfer
    codes.push_back(i2cmts_pkg::ST_START);
    codes.push_back(i2cmts_pkg::ST_SLA_W_ACK);
    if (count != 0) begin
      if (is_read) begin
        codes.push_back(i2cmts_pkg::ST_DATA_W_ACK);
        codes.push_back(i2cmts_pkg::ST_RSTART);
        codes.push_back(i2cmts_pkg::ST_SLA_R_ACK);
        repeat (count - 1) codes.push_back(i2cmts_pkg::ST_DATA_R_ACK);
        if ($urandom_range(0, 5) == 0) codes.push_back(i2cmts_pkg::ST_DATA_R_ACK);
        codes.push_back(i2cmts_pkg::ST_DATA_R_NACK);
      end else begin
        repeat (count + 1) codes.push_back(i2cmts_pkg::ST_DATA_W_ACK);
      end
    end

    // error injection: truncate and end on a failing status
    if ($urandom_range(0, 7) == 0) begin
      cut = $urandom_range(0, codes.size() - 1);
      while (codes.size() > cut + 1) void'(codes.pop_back());
      case ($urandom_range(0, 2))
        0: bad = ST_BUS_ERROR;
        1: bad = i2cmts_pkg::ST_ARB_LOST;
        default: begin
          do bad = 8'($urandom_range(0, 255));
          while (bad inside {i2cmts_pkg::ST_START, i2cmts_pkg::ST_RSTART,
                             i2cmts_pkg::ST_SLA_W_ACK, i2cmts_pkg::ST_DATA_W_ACK,
                             i2cmts_pkg::ST_SLA_R_ACK, i2cmts_pkg::ST_DATA_R_ACK});
        end
      endcase
      codes[cut] = bad;
    end

    foreach (codes[i]) begin
      // stray start or load while the transfer runs
      if (accepted && $urandom_range(0, 39) == 0) begin
        if ($urandom_range(0, 1) != 0) begin
          send_start(1'($urandom_range(0, 1)), 7'($urandom_range(0, 127)),
                     8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        end else begin
          send_load(8'($urandom_range(0, 255)));
        end
      end
      send_event(codes[i], 8'($urandom_range(0, 255)));
    end
  endtask

  // noise between transfers; a stray start is always followed by an ending status
  task automatic send_noise();
    i2cmts_pkg::in_item_t it;
    repeat ($urandom_range(1, 3)) begin
      it = random_item();
      send_item(it);
      if (it.op == i2cmts_pkg::OP_START) begin
        send_event(($urandom_range(0, 1) != 0) ? i2cmts_pkg::ST_ARB_LOST : ST_BUS_ERROR,
                   8'($urandom_range(0, 255)));
      end
    end
  endtask

  // stimulus
  initial begin
    i2cmts_pkg::in_item_t spare;
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.op = i2cmts_pkg::OP_START;
    in_ch.device_address = '0;
    in_ch.read_flag = 1'b0;
    in_ch.register_address = '0;
    in_ch.byte_count = '0;
    in_ch.write_byte = '0;
    in_ch.status_code = '0;
    in_ch.received_byte = '0;
    out_ch.ready = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: idle event, undefined op, write beyond an empty queue
    send_event(i2cmts_pkg::ST_START, 8'h00);
    spare = random_item();
    spare.op = OP_UNDEFINED;
    send_item(spare);
    send_start(1'b0, 7'h7F, 8'hFF, 8'd1);
    // write of two bytes, with a start and a load while busy
    send_load(8'hFF);
    send_load(8'h00);
    send_start(1'b0, 7'h7F, 8'hFF, 8'd2);
    send_start(1'b1, 7'h00, 8'h00, 8'hFF);
    send_load(8'hA5);
    send_event(i2cmts_pkg::ST_START, 8'hFF);
    send_event(i2cmts_pkg::ST_SLA_W_ACK, 8'h00);
    send_event(i2cmts_pkg::ST_DATA_W_ACK, 8'hFF);
    send_event(i2cmts_pkg::ST_DATA_W_ACK, 8'h00);
    send_event(i2cmts_pkg::ST_DATA_W_ACK, 8'hFF);
    // probe that hits a bus error
    send_start(1'b1, 7'h00, 8'h00, 8'd0);
    send_event(i2cmts_pkg::ST_START, 8'h00);
    send_event(ST_BUS_ERROR, 8'hFF);
    // one-byte read, an extra byte with no count left, then arbitration loss
    send_start(1'b1, 7'h2A, 8'h5A, 8'd1);
    send_event(i2cmts_pkg::ST_START, 8'h00);
    send_event(i2cmts_pkg::ST_SLA_W_ACK, 8'h00);
    send_event(i2cmts_pkg::ST_DATA_W_ACK, 8'h00);
    send_event(i2cmts_pkg::ST_RSTART, 8'h00);
    send_event(i2cmts_pkg::ST_SLA_R_ACK, 8'h00);
    send_event(i2cmts_pkg::ST_DATA_R_ACK, 8'hFF);
    send_event(i2cmts_pkg::ST_DATA_R_ACK, 8'h00);
    send_event(i2cmts_pkg::ST_ARB_LOST, 8'hFF);

    // random transfers with noise in between
    while (items_sent < TARGET_ITEMS) begin
      run_transfer();
      if ($urandom_range(0, 3) == 0) send_noise();
    end
    in_ch.valid <= 1'b0;

    // drain
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
